/* hdl/qrs_pkg.sv */
// Shared types and codes for the quadratic root solver.
// No dependencies.
package qrs_pkg;

    typedef enum logic [1:0] {
        KIND_NONE    = 2'd0,
        KIND_EQUAL   = 2'd1,
        KIND_TWO     = 2'd2,
        KIND_COMPLEX = 2'd3
    } root_kind_t;

    localparam int RAD_SHIFT = 32;  // radicand scale, root gets 16 extra fraction bits
    localparam int NUM_SHIFT = 16;  // -b is scaled to match the root
    localparam logic signed [31:0] SAT_MAX = 32'sh7fff_ffff;
    localparam logic signed [31:0] SAT_MIN = 32'sh8000_0000;

endpackage

/* hdl/qrs_sqrt_cell.sv */
// One restoring square-root digit step with a registered output.
// Standalone; instantiated in a chain by quadratic_root_solver.
module qrs_sqrt_cell #(
    parameter int RB = 33,
    parameter int SW = 34
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [2*RB-1:0]   in_x,
    input  logic [RB:0]       in_rem,
    input  logic [RB-1:0]     in_root,
    input  logic [SW-1:0]     in_side,
    output logic              out_valid,
    output logic [2*RB-1:0]   out_x,
    output logic [RB:0]       out_rem,
    output logic [RB-1:0]     out_root,
    output logic [SW-1:0]     out_side
);

    logic [RB+2:0]   rem_sh;
    logic [RB+2:0]   trial;
    logic [RB+2:0]   diff;
    logic            ge;
    logic            valid_reg;
    logic [2*RB-1:0] x_reg, x_next;
    logic [RB:0]     rem_reg, rem_next;
    logic [RB-1:0]   root_reg, root_next;
    logic [SW-1:0]   side_reg;

    always_comb
    begin
        rem_sh    = {in_rem, in_x[2*RB-1 -: 2]};
        trial     = {1'b0, in_root, 2'b01};
        diff      = rem_sh - trial;
        ge        = (rem_sh >= trial);
        rem_next  = ge ? diff[RB:0] : rem_sh[RB:0];
        root_next = {in_root[RB-2:0], ge};
        x_next    = {in_x[2*RB-3:0], 2'b00};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg    <= x_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
        side_reg <= in_side;
    end

    assign out_valid = valid_reg;
    assign out_x     = x_reg;
    assign out_rem   = rem_reg;
    assign out_root  = root_reg;
    assign out_side  = side_reg;

endmodule

/* hdl/qrs_div_cell.sv */
// One restoring division bit step for two lanes sharing a divisor.
// Standalone; instantiated in a chain by quadratic_root_solver.
module qrs_div_cell #(
    parameter int NM = 34,
    parameter int DM = 17,
    parameter int SW = 4
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  logic [DM-1:0] in_div,
    input  logic [DM-1:0] in_rem1,
    input  logic [NM-1:0] in_dq1,
    input  logic [DM-1:0] in_rem2,
    input  logic [NM-1:0] in_dq2,
    input  logic [SW-1:0] in_side,
    output logic          out_valid,
    output logic [DM-1:0] out_div,
    output logic [DM-1:0] out_rem1,
    output logic [NM-1:0] out_dq1,
    output logic [DM-1:0] out_rem2,
    output logic [NM-1:0] out_dq2,
    output logic [SW-1:0] out_side
);

    logic [DM:0]   r_sh1, r_sh2, d1, d2, div_x;
    logic          ge1, ge2;
    logic          valid_reg;
    logic [DM-1:0] div_reg;
    logic [DM-1:0] rem1_reg, rem1_next, rem2_reg, rem2_next;
    logic [NM-1:0] dq1_reg, dq1_next, dq2_reg, dq2_next;
    logic [SW-1:0] side_reg;

    always_comb
    begin
        div_x     = {1'b0, in_div};
        r_sh1     = {in_rem1, in_dq1[NM-1]};
        r_sh2     = {in_rem2, in_dq2[NM-1]};
        ge1       = (r_sh1 >= div_x);
        ge2       = (r_sh2 >= div_x);
        d1        = r_sh1 - div_x;
        d2        = r_sh2 - div_x;
        rem1_next = ge1 ? d1[DM-1:0] : r_sh1[DM-1:0];
        rem2_next = ge2 ? d2[DM-1:0] : r_sh2[DM-1:0];
        // dividend shifts out the top while quotient bits enter at the bottom
        dq1_next  = {in_dq1[NM-2:0], ge1};
        dq2_next  = {in_dq2[NM-2:0], ge2};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        div_reg  <= in_div;
        rem1_reg <= rem1_next;
        rem2_reg <= rem2_next;
        dq1_reg  <= dq1_next;
        dq2_reg  <= dq2_next;
        side_reg <= in_side;
    end

    assign out_valid = valid_reg;
    assign out_div   = div_reg;
    assign out_rem1  = rem1_reg;
    assign out_dq1   = dq1_reg;
    assign out_rem2  = rem2_reg;
    assign out_dq2   = dq2_reg;
    assign out_side  = side_reg;

endmodule

/* hdl/quadratic_root_solver.sv */
// Quadratic root solver top level: products, discriminant, sqrt chain, divider chain.
// Depends on qrs_pkg, qrs_sqrt_cell, qrs_div_cell.
//
// channel   direction  handshake        fields
// command   in         start / busy     coef_a, coef_b, coef_c
// result    out        done (1 cycle)   root_kind, first_value, second_value, overflow_flag
//
// One transaction per cycle; busy is always low.
// The pipeline has COEF_WIDTH+17 sqrt cells, COEF_WIDTH+18 divide
// cells and four arithmetic stages.
// Reset clears only the valid bits of the pipeline.
// done pulses for one cycle per transaction; the receiver cannot stall.
module quadratic_root_solver #(
    parameter int COEF_WIDTH = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic signed [COEF_WIDTH-1:0] coef_a,
    input  logic signed [COEF_WIDTH-1:0] coef_b,
    input  logic signed [COEF_WIDTH-1:0] coef_c,
    output logic                         done,
    output logic [1:0]                   root_kind,
    output logic signed [31:0]           first_value,
    output logic signed [31:0]           second_value,
    output logic                         overflow_flag
);

    localparam int W   = COEF_WIDTH;
    localparam int DW  = 2*W + 1;          // |discriminant|
    localparam int RB  = W + 17;           // root bits
    localparam int NW  = W + 19;           // signed numerator
    localparam int NM  = W + 18;           // numerator magnitude
    localparam int DM  = W + 1;            // divisor magnitude
    localparam int EW  = (NW > 33) ? NW : 33;
    localparam int SSW = 2 + 2*W;
    localparam int DSW = 4;

    // stage 1: products
    logic                  s1_valid_reg;
    logic signed [W-1:0]   s1_a_reg, s1_b_reg;
    logic signed [2*W-1:0] s1_bb_reg, s1_ac_reg, s1_bb_next, s1_ac_next;

    assign busy       = 1'b0;
    assign s1_bb_next = coef_b * coef_b;
    assign s1_ac_next = coef_a * coef_c;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= start;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_a_reg  <= coef_a;
        s1_b_reg  <= coef_b;
        s1_bb_reg <= s1_bb_next;
        s1_ac_reg <= s1_ac_next;
    end

    // stage 2: discriminant and case
    logic                  s2_valid_reg;
    logic signed [W-1:0]   s2_a_reg, s2_b_reg;
    logic [DW-1:0]         s2_mag_reg, s2_mag_next;
    qrs_pkg::root_kind_t   s2_kind_reg, s2_kind_next;
    logic signed [2*W+2:0] disc;
    logic signed [2*W+2:0] disc_abs;

    always_comb
    begin
        disc = $signed({3'b000, s1_bb_reg})
             - ($signed({{3{s1_ac_reg[2*W-1]}}, s1_ac_reg}) <<< 2);
        disc_abs    = disc[2*W+2] ? -disc : disc;
        s2_mag_next = disc_abs[DW-1:0];
        if (s1_a_reg == '0)
        begin
            s2_kind_next = qrs_pkg::KIND_NONE;
        end
        else if (disc == '0)
        begin
            s2_kind_next = qrs_pkg::KIND_EQUAL;
        end
        else if (disc[2*W+2])
        begin
            s2_kind_next = qrs_pkg::KIND_COMPLEX;
        end
        else
        begin
            s2_kind_next = qrs_pkg::KIND_TWO;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s2_a_reg    <= s1_a_reg;
        s2_b_reg    <= s1_b_reg;
        s2_mag_reg  <= s2_mag_next;
        s2_kind_reg <= s2_kind_next;
    end

    // square root chain over |d| * 2^32
    logic              sq_v    [0:RB];
    logic [2*RB-1:0]   sq_x    [0:RB];
    logic [RB:0]       sq_rem  [0:RB];
    logic [RB-1:0]     sq_root [0:RB];
    logic [SSW-1:0]    sq_side [0:RB];

    assign sq_v[0]    = s2_valid_reg;
    assign sq_x[0]    = {1'b0, s2_mag_reg, {qrs_pkg::RAD_SHIFT{1'b0}}};
    assign sq_rem[0]  = '0;
    assign sq_root[0] = '0;
    assign sq_side[0] = {s2_kind_reg, s2_a_reg, s2_b_reg};

    for (genvar i = 0; i < RB; i++)
    begin : g_sqrt
        qrs_sqrt_cell #(.RB(RB), .SW(SSW)) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .in_valid (sq_v[i]),
            .in_x     (sq_x[i]),
            .in_rem   (sq_rem[i]),
            .in_root  (sq_root[i]),
            .in_side  (sq_side[i]),
            .out_valid(sq_v[i+1]),
            .out_x    (sq_x[i+1]),
            .out_rem  (sq_rem[i+1]),
            .out_root (sq_root[i+1]),
            .out_side (sq_side[i+1])
        );
    end

    // stage 3: numerators and divisor as magnitudes plus signs
    logic                s3_valid_reg;
    logic [NM-1:0]       s3_m1_reg, s3_m2_reg, s3_m1_next, s3_m2_next;
    logic [DM-1:0]       s3_den_reg, s3_den_next;
    logic [DSW-1:0]      s3_side_reg, s3_side_next;
    logic [1:0]          t_kind;
    logic signed [W-1:0] t_a, t_b;
    logic signed [NW-1:0] nb, sx, num1, num2, abs1, abs2;
    logic signed [W:0]   ax, aabs;

    always_comb
    begin
        t_kind = sq_side[RB][SSW-1 -: 2];
        t_a    = sq_side[RB][2*W-1:W];
        t_b    = sq_side[RB][W-1:0];
        nb     = -(NW'(t_b) <<< qrs_pkg::NUM_SHIFT);
        sx     = $signed({{(NW-RB){1'b0}}, sq_root[RB]});
        if (t_kind == qrs_pkg::KIND_COMPLEX)
        begin
            num1 = nb;
            num2 = sx;
        end
        else
        begin
            num1 = nb + sx;
            num2 = nb - sx;
        end
        abs1        = num1[NW-1] ? -num1 : num1;
        abs2        = num2[NW-1] ? -num2 : num2;
        s3_m1_next  = abs1[NM-1:0];
        s3_m2_next  = abs2[NM-1:0];
        ax          = (W+1)'(t_a);
        aabs        = ax[W] ? -ax : ax;
        s3_den_next = {aabs[W-1:0], 1'b0};
        s3_side_next = {t_kind, num1[NW-1] ^ t_a[W-1], num2[NW-1] ^ t_a[W-1]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s3_valid_reg <= sq_v[RB];
        end
    end

    always_ff @(posedge clk)
    begin
        s3_m1_reg   <= s3_m1_next;
        s3_m2_reg   <= s3_m2_next;
        s3_den_reg  <= s3_den_next;
        s3_side_reg <= s3_side_next;
    end

    // divider chain, both roots share the divisor 2|a|
    logic           dv_v    [0:NM];
    logic [DM-1:0]  dv_div  [0:NM];
    logic [DM-1:0]  dv_rem1 [0:NM];
    logic [NM-1:0]  dv_dq1  [0:NM];
    logic [DM-1:0]  dv_rem2 [0:NM];
    logic [NM-1:0]  dv_dq2  [0:NM];
    logic [DSW-1:0] dv_side [0:NM];

    assign dv_v[0]    = s3_valid_reg;
    assign dv_div[0]  = s3_den_reg;
    assign dv_rem1[0] = '0;
    assign dv_dq1[0]  = s3_m1_reg;
    assign dv_rem2[0] = '0;
    assign dv_dq2[0]  = s3_m2_reg;
    assign dv_side[0] = s3_side_reg;

    for (genvar j = 0; j < NM; j++)
    begin : g_div
        qrs_div_cell #(.NM(NM), .DM(DM), .SW(DSW)) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .in_valid (dv_v[j]),
            .in_div   (dv_div[j]),
            .in_rem1  (dv_rem1[j]),
            .in_dq1   (dv_dq1[j]),
            .in_rem2  (dv_rem2[j]),
            .in_dq2   (dv_dq2[j]),
            .in_side  (dv_side[j]),
            .out_valid(dv_v[j+1]),
            .out_div  (dv_div[j+1]),
            .out_rem1 (dv_rem1[j+1]),
            .out_dq1  (dv_dq1[j+1]),
            .out_rem2 (dv_rem2[j+1]),
            .out_dq2  (dv_dq2[j+1]),
            .out_side (dv_side[j+1])
        );
    end

    // stage 4: sign, saturate, output registers
    logic                done_reg;
    logic [1:0]          kind_reg, kind_next;
    logic signed [31:0]  v1_reg, v1_next, v2_reg, v2_next;
    logic                ovf_reg, ovf_next;
    logic signed [EW-1:0] q1, q2, sat_hi, sat_lo;
    logic                hi1, lo1, hi2, lo2;

    always_comb
    begin
        sat_hi = EW'(qrs_pkg::SAT_MAX);
        sat_lo = EW'(qrs_pkg::SAT_MIN);
        q1 = $signed({{(EW-NM){1'b0}}, dv_dq1[NM]});
        q2 = $signed({{(EW-NM){1'b0}}, dv_dq2[NM]});
        if (dv_side[NM][1])
        begin
            q1 = -q1;
        end
        if (dv_side[NM][0])
        begin
            q2 = -q2;
        end
        hi1 = (q1 > sat_hi);
        lo1 = (q1 < sat_lo);
        hi2 = (q2 > sat_hi);
        lo2 = (q2 < sat_lo);
        kind_next = dv_side[NM][3:2];
        if (kind_next == qrs_pkg::KIND_NONE)
        begin
            v1_next  = '0;
            v2_next  = '0;
            ovf_next = 1'b0;
        end
        else
        begin
            v1_next  = hi1 ? qrs_pkg::SAT_MAX : (lo1 ? qrs_pkg::SAT_MIN : q1[31:0]);
            v2_next  = hi2 ? qrs_pkg::SAT_MAX : (lo2 ? qrs_pkg::SAT_MIN : q2[31:0]);
            ovf_next = hi1 | lo1 | hi2 | lo2;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= dv_v[NM];
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg <= kind_next;
        v1_reg   <= v1_next;
        v2_reg   <= v2_next;
        ovf_reg  <= ovf_next;
    end

    assign done          = done_reg;
    assign root_kind     = kind_reg;
    assign first_value   = v1_reg;
    assign second_value  = v2_reg;
    assign overflow_flag = ovf_reg;

    a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && root_kind == qrs_pkg::KIND_NONE
        |-> first_value == '0 && second_value == '0 && !overflow_flag)
        else $error("not-quadratic result carries nonzero values");

    a_equal_same: assert property (@(posedge clk) disable iff (!rst_n)
        done && root_kind == qrs_pkg::KIND_EQUAL |-> first_value == second_value)
        else $error("equal roots differ");

    a_ovf_rail: assert property (@(posedge clk) disable iff (!rst_n)
        done && overflow_flag
        |-> first_value == qrs_pkg::SAT_MAX || first_value == qrs_pkg::SAT_MIN
            || second_value == qrs_pkg::SAT_MAX || second_value == qrs_pkg::SAT_MIN)
        else $error("overflow flagged without a saturated value");

endmodule
